// ===== hw/rtl/vsm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, register codes and types of the view sharing mask
package vsm_pkg;

   localparam int READOUT_MAX = 4096;
   localparam int FRAME_MAX   = 256;
   localparam int SHAPE_MAX   = 8;

   localparam int VAL_W  = 40;
   localparam int FRAC_W = 16;
   localparam int DIV_W  = VAL_W + 1;
   localparam int DC_W   = 27;
   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_MODE           = 3'd0;
   localparam logic [2:0] REG_WIDTH_CENTER   = 3'd1;
   localparam logic [2:0] REG_WIDTH_EDGE     = 3'd2;
   localparam logic [2:0] REG_SHAPE_POWER    = 3'd3;
   localparam logic [2:0] REG_CURRENT_FRAME  = 3'd4;
   localparam logic [2:0] REG_FRAME_COUNT    = 3'd5;
   localparam logic [2:0] REG_READOUT_LENGTH = 3'd6;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_SLIDING = 2'd1;
   localparam logic [1:0] MODE_TORNADO = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  width_center;
      logic [8:0]  width_edge;
      logic [3:0]  shape_power;
      logic [7:0]  current_frame;
      logic [8:0]  frame_count;
      logic [12:0] readout_length;
   } cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] h;
      logic signed [VAL_W-1:0] cc;
      logic signed [VAL_W-1:0] fcl;
      logic signed [VAL_W-1:0] fcr;
   } derive_type;

endpackage

// ===== hw/rtl/view_sharing_mask_top.sv =====
`timescale 1ns / 1ps
// view sharing mask top level: register file, geometry unit, sample pipeline
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     sample_time, spoke_time, readout_index
//   rsp      out        rsp_valid / rsp_ready     keep
//   csr      in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// one beat per cycle unless rsp stalls or a geometry update holds req_ready low;
// beats run through the one-bit-per-stage ratio divider and the power multiplier chain
// after reset and after every register write the geometry unit runs its serial divider;
// req_ready is low meanwhile
// a stalled rsp beat freezes the whole pipeline; nothing is dropped or repeated
module view_sharing_mask_top #(
   parameter int READOUT_MAX = vsm_pkg::READOUT_MAX,
   parameter int FRAME_MAX   = vsm_pkg::FRAME_MAX,
   parameter int SHAPE_MAX   = vsm_pkg::SHAPE_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [15:0]                req_sample_time,
   input  logic [15:0]                req_spoke_time,
   input  logic [11:0]                req_readout_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_keep,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [vsm_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   vsm_pkg::cfg_type    cfg;
   vsm_pkg::derive_type drv;
   logic                change;
   logic                busy;

   vsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .change  (change)
   );

   vsm_derive #(
      .FRAME_MAX (FRAME_MAX)
   ) u_derive (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .start (change),
      .drv   (drv),
      .busy  (busy)
   );

   vsm_pipe #(
      .READOUT_MAX (READOUT_MAX),
      .SHAPE_MAX   (SHAPE_MAX)
   ) u_pipe (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .drv               (drv),
      .hold              (busy | change),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_time   (req_sample_time),
      .req_spoke_time    (req_spoke_time),
      .req_readout_index (req_readout_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_keep          (rsp_keep)
   );

   a_no_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !busy && !change)
      else $error("beat accepted during geometry update");

endmodule

// ===== hw/rtl/vsm_csr.sv =====
`timescale 1ns / 1ps
// apb register file of the view sharing mask
module vsm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [vsm_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output vsm_pkg::cfg_type           cfg,
   output logic                       change
);

   vsm_pkg::cfg_type cfg_ff;
   logic             change_ff;
   logic             wr_en;
   logic [2:0]       idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[vsm_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= vsm_pkg::MODE_NONE;
         cfg_ff.width_center   <= 8'd1;
         cfg_ff.width_edge     <= 9'd4;
         cfg_ff.shape_power    <= 4'd3;
         cfg_ff.current_frame  <= 8'd0;
         cfg_ff.frame_count    <= 9'd32;
         cfg_ff.readout_length <= 13'd256;
         change_ff             <= 1'b1;
      end else begin
         change_ff <= wr_en;
         if (wr_en) begin
            unique case (idx)
               vsm_pkg::REG_MODE:           cfg_ff.mode           <= pwdata[1:0];
               vsm_pkg::REG_WIDTH_CENTER:   cfg_ff.width_center   <= pwdata[7:0];
               vsm_pkg::REG_WIDTH_EDGE:     cfg_ff.width_edge     <= pwdata[8:0];
               vsm_pkg::REG_SHAPE_POWER:    cfg_ff.shape_power    <= pwdata[3:0];
               vsm_pkg::REG_CURRENT_FRAME:  cfg_ff.current_frame  <= pwdata[7:0];
               vsm_pkg::REG_FRAME_COUNT:    cfg_ff.frame_count    <= pwdata[8:0];
               vsm_pkg::REG_READOUT_LENGTH: cfg_ff.readout_length <= pwdata[12:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         vsm_pkg::REG_MODE:           prdata = {30'd0, cfg_ff.mode};
         vsm_pkg::REG_WIDTH_CENTER:   prdata = {24'd0, cfg_ff.width_center};
         vsm_pkg::REG_WIDTH_EDGE:     prdata = {23'd0, cfg_ff.width_edge};
         vsm_pkg::REG_SHAPE_POWER:    prdata = {28'd0, cfg_ff.shape_power};
         vsm_pkg::REG_CURRENT_FRAME:  prdata = {24'd0, cfg_ff.current_frame};
         vsm_pkg::REG_FRAME_COUNT:    prdata = {23'd0, cfg_ff.frame_count};
         vsm_pkg::REG_READOUT_LENGTH: prdata = {19'd0, cfg_ff.readout_length};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg    = cfg_ff;
   assign change = change_ff;

endmodule

// ===== hw/rtl/vsm_derive.sv =====
`timescale 1ns / 1ps
// per-configuration tornado geometry: center step divider and skirt widths
module vsm_derive #(
   parameter int FRAME_MAX = vsm_pkg::FRAME_MAX
) (
   input  logic                clock,
   input  logic                reset,
   input  vsm_pkg::cfg_type    cfg,
   input  logic                start,
   output vsm_pkg::derive_type drv,
   output logic                busy
);

   localparam int VAL_W = vsm_pkg::VAL_W;
   localparam int DC_W  = vsm_pkg::DC_W;
   localparam int CNT_W = $clog2(DC_W + 2);

   logic [8:0]               f_q;
   logic [8:0]               den;
   logic signed [10:0]       a0, b0, a_s, b_s, b_c, f_s;
   logic signed [11:0]       d_ab, fa;
   logic [10:0]              fa_abs;
   logic [DC_W-1:0]          n_mag;
   logic signed [VAL_W-1:0]  h_c, fc_c, f16, cc_in, l_c, r_c, fcl_c, fcr_c;
   logic signed [DC_W:0]     dc;
   logic signed [DC_W+9:0]   prod;
   logic [9:0]               rem2, rem_dif;
   logic                     ge;

   logic                     busy_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [8:0]               rem_ff;
   logic [DC_W-1:0]          quo_ff;
   logic                     neg_ff;
   logic signed [VAL_W-1:0]  h_ff, cc_ff, fcl_ff, fcr_ff;

   always_comb begin
      if (cfg.frame_count < 9'd2) begin
         f_q = 9'd2;
      end else if (int'(cfg.frame_count) > FRAME_MAX) begin
         f_q = 9'(FRAME_MAX);
      end else begin
         f_q = cfg.frame_count;
      end
      f_s = $signed({2'b00, f_q});
      a0  = $signed({3'b000, cfg.width_center});
      b0  = $signed({{2{cfg.width_edge[8]}}, cfg.width_edge});
      if (a0 == b0) begin
         a_s = a0;
         b_s = b0 + 11'sd1;
      end else if (a0 > b0) begin
         a_s = b0;
         b_s = a0;
      end else begin
         a_s = a0;
         b_s = b0;
      end
      b_c    = (b_s > f_s) ? f_s : b_s;
      d_ab   = {b_c[10], b_c} - {a_s[10], a_s};
      fa     = {f_s[10], f_s} - {a_s[10], a_s};
      fa_abs = fa[11] ? 11'(-fa) : fa[10:0];
      n_mag  = {fa_abs, 16'd0};
      den    = f_q - 9'd1;
      h_c    = $signed({{(VAL_W-26){a_s[10]}}, a_s, 15'd0});
      fc_c   = $signed({{(VAL_W-27){d_ab[11]}}, d_ab, 15'd0});
      f16    = $signed({{(VAL_W-25){1'b0}}, f_q, 16'd0});
   end

   // one quotient bit per cycle
   assign rem2    = {rem_ff, quo_ff[DC_W-1]};
   assign ge      = rem2 >= {1'b0, den};
   assign rem_dif = rem2 - {1'b0, den};

   always_comb begin
      dc    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      prod  = dc * $signed({1'b0, cfg.current_frame});
      cc_in = h_c + VAL_W'(prod);
      l_c   = cc_ff - h_c - fc_c;
      r_c   = cc_ff + h_c + fc_c - f16;
      fcl_c = fc_c;
      fcr_c = fc_c;
      if (l_c < 0) begin
         fcl_c = fcl_c + l_c;
         fcr_c = fcr_c - l_c;
      end
      if (r_c > 0) begin
         fcr_c = fcr_c - r_c;
         fcl_c = fcl_c + r_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DC_W + 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= n_mag;
         neg_ff <= fa[11];
      end else if (busy_ff) begin
         if (cnt_ff < CNT_W'(DC_W)) begin
            rem_ff <= ge ? rem_dif[8:0] : rem2[8:0];
            quo_ff <= {quo_ff[DC_W-2:0], ge};
         end else if (cnt_ff == CNT_W'(DC_W)) begin
            cc_ff <= cc_in;
         end else begin
            h_ff   <= h_c;
            fcl_ff <= fcl_c;
            fcr_ff <= fcr_c;
         end
      end
   end

   assign drv.h   = h_ff;
   assign drv.cc  = cc_ff;
   assign drv.fcl = fcl_ff;
   assign drv.fcr = fcr_ff;
   assign busy    = busy_ff;

   a_full_pass: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(cnt_ff) == CNT_W'(DC_W + 1))
      else $error("geometry update ended early");

endmodule

// ===== hw/rtl/vsm_pipe.sv =====
`timescale 1ns / 1ps
// per-sample decision pipeline: window tests, ratio divider, power, cutoff
module vsm_pipe #(
   parameter int READOUT_MAX = vsm_pkg::READOUT_MAX,
   parameter int SHAPE_MAX   = vsm_pkg::SHAPE_MAX
) (
   input  logic                clock,
   input  logic                reset,
   input  vsm_pkg::cfg_type    cfg,
   input  vsm_pkg::derive_type drv,
   input  logic                hold,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_sample_time,
   input  logic [15:0]         req_spoke_time,
   input  logic [11:0]         req_readout_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_keep
);

   localparam int VAL_W  = vsm_pkg::VAL_W;
   localparam int FRAC_W = vsm_pkg::FRAC_W;
   localparam int DIV_W  = vsm_pkg::DIV_W;

   typedef struct packed {
      logic        tor;
      logic        simple;
      logic        skirt;
      logic        ckeep;
      logic [11:0] idx;
   } side_type;

   logic en, acc;

   // input stage
   logic signed [9:0]       idif;
   logic signed [9:0]       a10;
   logic                    simple_c;
   logic signed [VAL_W-1:0] fdif_in;
   logic                    vld_a_ff;
   side_type                side_a_ff;
   logic signed [VAL_W-1:0] fdif_a_ff;

   // window tests
   logic signed [VAL_W-1:0] absf, num_c, den_c;
   logic                    right_c, left_c, center_c;

   // divider
   logic                    vld_ff  [0:FRAC_W];
   side_type                side_ff [0:FRAC_W];
   logic [FRAC_W-1:0]       q_ff    [0:FRAC_W];
   logic [DIV_W-1:0]        rem_ff  [0:FRAC_W-1];
   logic [DIV_W-1:0]        den_ff  [0:FRAC_W-1];

   // power
   logic [4:0]              pc;
   logic                    vld_p_ff  [0:SHAPE_MAX];
   side_type                side_p_ff [0:SHAPE_MAX];
   logic [FRAC_W:0]         pw_ff     [0:SHAPE_MAX];
   logic [FRAC_W-1:0]       r_ff      [0:SHAPE_MAX];

   // cutoff
   logic [12:0]             si;
   logic                    vld_t_ff;
   side_type                side_t_ff;
   logic [29:0]             prod_t_ff;
   logic [30:0]             ceil_sum;
   logic [12:0]             til;
   logic                    keep_c;
   logic                    rsp_valid_ff;
   logic                    rsp_keep_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !hold;
   assign acc       = req_valid && req_ready;

   always_comb begin
      idif = $signed({2'b00, req_sample_time[15:8]}) - $signed({2'b00, cfg.current_frame});
      a10  = $signed({2'b00, cfg.width_center});
      case (cfg.mode)
         vsm_pkg::MODE_SLIDING: begin
            if (cfg.width_edge[8]) begin
               simple_c = (idif <= 0) && (idif >= -a10);
            end else if (cfg.width_edge != 9'd0) begin
               simple_c = (idif >= 0) && (idif <= a10);
            end else begin
               simple_c = (idif <= a10) && (idif >= -a10);
            end
         end
         default: simple_c = (idif == 0);
      endcase
      fdif_in = $signed({{(VAL_W-24){1'b0}}, req_spoke_time, 8'd0}) - drv.cc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff.tor    <= (cfg.mode == vsm_pkg::MODE_TORNADO);
         side_a_ff.simple <= simple_c;
         side_a_ff.skirt  <= 1'b0;
         side_a_ff.ckeep  <= 1'b0;
         side_a_ff.idx    <= req_readout_index;
         fdif_a_ff        <= fdif_in;
      end
   end

   always_comb begin
      absf     = fdif_a_ff[VAL_W-1] ? -fdif_a_ff : fdif_a_ff;
      right_c  = (absf < drv.fcr + drv.h) && (fdif_a_ff > drv.h);
      left_c   = (absf < drv.fcl + drv.h) && (fdif_a_ff < -drv.h);
      center_c = absf < drv.h;
      if (right_c) begin
         num_c = drv.fcr - fdif_a_ff + drv.h;
         den_c = drv.fcr;
      end else begin
         num_c = drv.fcl + fdif_a_ff + drv.h;
         den_c = drv.fcl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= {side_a_ff.tor, side_a_ff.simple, right_c || left_c, center_c,
                        side_a_ff.idx};
         q_ff[0]    <= '0;
         rem_ff[0]  <= {1'b0, num_c};
         den_ff[0]  <= {1'b0, den_c};
      end
   end

   for (genvar k = 0; k < FRAC_W; k++) begin : g_div
      logic [DIV_W-1:0] two, dif;
      logic             ge;

      assign two = {rem_ff[k][DIV_W-2:0], 1'b0};
      assign ge  = two >= den_ff[k];
      assign dif = two - den_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            q_ff[k+1]    <= {q_ff[k][FRAC_W-2:0], ge};
         end
      end

      if (k < FRAC_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge ? dif : two;
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   assign pc = (int'(cfg.shape_power) > SHAPE_MAX) ? 5'(SHAPE_MAX) : {1'b0, cfg.shape_power};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff[0] <= 1'b0;
      end else if (en) begin
         vld_p_ff[0] <= vld_ff[FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_p_ff[0] <= side_ff[FRAC_W];
         pw_ff[0]     <= {1'b1, {FRAC_W{1'b0}}};
         r_ff[0]      <= q_ff[FRAC_W];
      end
   end

   for (genvar j = 0; j < SHAPE_MAX; j++) begin : g_pow
      logic [2*FRAC_W:0] m;

      assign m = pw_ff[j] * r_ff[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_p_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_p_ff[j+1] <= vld_p_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_p_ff[j+1] <= side_p_ff[j];
            r_ff[j+1]      <= r_ff[j];
            pw_ff[j+1]     <= (5'(j) < pc) ? m[2*FRAC_W:FRAC_W] : pw_ff[j];
         end
      end
   end

   assign si = (int'(cfg.readout_length) > READOUT_MAX) ? 13'(READOUT_MAX) : cfg.readout_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_t_ff <= 1'b0;
      end else if (en) begin
         vld_t_ff <= vld_p_ff[SHAPE_MAX];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_t_ff <= side_p_ff[SHAPE_MAX];
         prod_t_ff <= si * pw_ff[SHAPE_MAX];
      end
   end

   always_comb begin
      ceil_sum = {1'b0, prod_t_ff} + 31'd65535;
      til      = si - ceil_sum[28:16];
      if (!side_t_ff.tor) begin
         keep_c = side_t_ff.simple;
      end else if (side_t_ff.skirt) begin
         keep_c = {1'b0, side_t_ff.idx} >= til;
      end else begin
         keep_c = side_t_ff.ckeep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_keep_ff <= keep_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_keep  = rsp_keep_ff;

   a_ratio_below_one: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && side_ff[0].tor && side_ff[0].skirt |-> rem_ff[0] < den_ff[0])
      else $error("skirt ratio not below one");

   a_til_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_t_ff && side_t_ff.tor && side_t_ff.skirt |-> ceil_sum[30:16] <= {2'b00, si})
      else $error("cutoff beyond readout length");

endmodule

// ===== tb/view_sharing_mask_top_tb.sv =====
`timescale 1ns / 1ps
// testbench of the view sharing mask: directed and random samples checked against a predictor
module view_sharing_mask_top_tb;

   localparam int LATENCY   = vsm_pkg::FRAC_W + vsm_pkg::SHAPE_MAX + 5;
   localparam int GEO_WAIT  = vsm_pkg::DC_W + 3;
   localparam int LIMIT     = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_sample_time = '0;
   logic [15:0] req_spoke_time = '0;
   logic [11:0] req_readout_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_keep;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [vsm_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // register shadow
   logic [1:0]  sh_mode;
   logic [7:0]  sh_wc;
   logic [8:0]  sh_we;
   logic [3:0]  sh_pw;
   logic [7:0]  sh_cur;
   logic [8:0]  sh_fc;
   logic [12:0] sh_rl;

   bit   keep_queue[$];
   int   mismatches = 0;
   int   stall_hold = 0;
   bit   failed = 0;
   longint cycles = 0;

   view_sharing_mask_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_time(req_sample_time), .req_spoke_time(req_spoke_time),
      .req_readout_index(req_readout_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_keep(rsp_keep),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit skirt_keep(longint num, longint den, logic [11:0] idx);
      longint r, pwv, si, til;
      int p;
      r = (num * 65536) / den;
      if (r > 65535) r = 65535;
      p = (sh_pw > vsm_pkg::SHAPE_MAX) ? vsm_pkg::SHAPE_MAX : sh_pw;
      si = (sh_rl > vsm_pkg::READOUT_MAX) ? vsm_pkg::READOUT_MAX : sh_rl;
      pwv = 65536;
      for (int k = 0; k < p; k++) pwv = (pwv * r) >>> 16;
      til = si - ((si * pwv + 65535) >>> 16);
      return longint'(idx) >= til;
   endfunction

   function automatic bit predict_keep(logic [15:0] st, logic [15:0] sp, logic [11:0] idx);
      longint idif, f, a, b, tmp, h, fcw, dc, cc, fcl, fcr, l, r, fdif, af, we;
      idif = longint'(st[15:8]) - longint'(sh_cur);
      we = longint'($signed(sh_we));
      if (sh_mode == vsm_pkg::MODE_TORNADO) begin
         f = sh_fc;
         if (f < 2) f = 2;
         if (f > vsm_pkg::FRAME_MAX) f = vsm_pkg::FRAME_MAX;
         a = sh_wc;
         b = we;
         if (a == b) b = b + 1;
         else if (a > b) begin
            tmp = a; a = b; b = tmp;
         end
         if (b > f) b = f;
         h = a * 32768;
         fcw = (b - a) * 32768;
         dc = ((f - a) * 65536) / (f - 1);
         cc = h + dc * longint'(sh_cur);
         fcl = fcw;
         fcr = fcw;
         l = cc - h - fcw;
         if (l < 0) begin
            fcl += l; fcr -= l;
         end
         r = cc + h + fcw - f * 65536;
         if (r > 0) begin
            fcr -= r; fcl += r;
         end
         fdif = longint'(sp) * 256 - cc;
         af = fdif < 0 ? -fdif : fdif;
         if (af < fcr + h && fdif > h) return skirt_keep(fcr - fdif + h, fcr, idx);
         if (af < fcl + h && fdif < -h) return skirt_keep(fcl + fdif + h, fcl, idx);
         return af < h;
      end
      if (sh_mode == vsm_pkg::MODE_SLIDING) begin
         a = sh_wc;
         if (we < 0) return idif <= 0 && idif >= -a;
         if (we > 0) return idif >= 0 && idif <= a;
         return (idif < 0 ? -idif : idif) <= a;
      end
      return idif == 0;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (keep_queue.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat keep=%0b", rsp_keep);
         end else begin
            bit want;
            want = keep_queue.pop_front();
            if (rsp_keep !== want) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("keep mismatch: expected %0b actual %0b", want, rsp_keep);
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_ready <= 1'b0;
         if ($urandom_range(0, 19) == 0) stall_hold <= $urandom_range(10, 60);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= vsm_pkg::ADDR_W'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         vsm_pkg::REG_MODE:           sh_mode = val[1:0];
         vsm_pkg::REG_WIDTH_CENTER:   sh_wc = val[7:0];
         vsm_pkg::REG_WIDTH_EDGE:     sh_we = val[8:0];
         vsm_pkg::REG_SHAPE_POWER:    sh_pw = val[3:0];
         vsm_pkg::REG_CURRENT_FRAME:  sh_cur = val[7:0];
         vsm_pkg::REG_FRAME_COUNT:    sh_fc = val[8:0];
         vsm_pkg::REG_READOUT_LENGTH: sh_rl = val[12:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (keep_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_config(logic [1:0] md, logic [7:0] wc, logic [8:0] we, logic [3:0] pw,
                             logic [7:0] cur, logic [8:0] fc, logic [12:0] rl);
      drain();
      csr_write(vsm_pkg::REG_MODE, 32'(md));
      csr_write(vsm_pkg::REG_WIDTH_CENTER, 32'(wc));
      csr_write(vsm_pkg::REG_WIDTH_EDGE, 32'(we));
      csr_write(vsm_pkg::REG_SHAPE_POWER, 32'(pw));
      csr_write(vsm_pkg::REG_CURRENT_FRAME, 32'(cur));
      csr_write(vsm_pkg::REG_FRAME_COUNT, 32'(fc));
      csr_write(vsm_pkg::REG_READOUT_LENGTH, 32'(rl));
   endtask

   task automatic send_sample(logic [15:0] st, logic [15:0] sp, logic [11:0] idx, bit gaps);
      int gap;
      if (gaps && $urandom_range(0, 99) < 20) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_time <= st;
      req_spoke_time <= sp;
      req_readout_index <= idx;
      keep_queue.push_back(predict_keep(st, sp, idx));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_defaults();
      send_sample(16'h0000, 16'h0000, 12'd0, 1'b0);
      send_sample(16'h00FF, 16'hFFFF, 12'd4095, 1'b0);
      send_sample(16'h0100, 16'h8000, 12'd100, 1'b0);
      send_sample(16'hFFFF, 16'h0100, 12'd1, 1'b0);
      end_burst();
   endtask

   task automatic test_modes_directed();
      set_config(vsm_pkg::MODE_SLIDING, 8'd2, 9'h1FF, 4'd3, 8'd5, 9'd32, 13'd256);
      for (int d = 2; d <= 8; d++) send_sample(16'(d << 8), 16'h0, 12'd0, 1'b0);
      end_burst();
      set_config(vsm_pkg::MODE_SLIDING, 8'd2, 9'h001, 4'd3, 8'd5, 9'd32, 13'd256);
      for (int d = 2; d <= 8; d++) send_sample(16'(d << 8) | 16'h80, 16'h0, 12'd0, 1'b0);
      end_burst();
      set_config(vsm_pkg::MODE_SLIDING, 8'd0, 9'h000, 4'd3, 8'd255, 9'd32, 13'd256);
      send_sample(16'hFF00, 16'h0, 12'd0, 1'b0);
      send_sample(16'hFE00, 16'h0, 12'd0, 1'b0);
      end_burst();
      set_config(2'd3, 8'd1, 9'd4, 4'd3, 8'd7, 9'd32, 13'd256);
      send_sample(16'h0700, 16'h0, 12'd0, 1'b0);
      send_sample(16'h0800, 16'h0, 12'd0, 1'b0);
      end_burst();
      // tornado: center boundary, skirts, zero power, zero readout
      set_config(vsm_pkg::MODE_TORNADO, 8'd2, 9'd6, 4'd0, 8'd10, 9'd32, 13'd0);
      for (int s = 0; s < 6; s++)
         send_sample(16'h0, 16'(s * 16'h0180 + 16'h0800), 12'd0, 1'b0);
      end_burst();
      set_config(vsm_pkg::MODE_TORNADO, 8'd255, 9'h101, 4'd15, 8'd255, 9'd511, 13'd8191);
      for (int s = 0; s < 4; s++)
         send_sample(16'h0, 16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                     1'b0);
      end_burst();
   endtask

   task automatic random_config();
      logic [8:0] fc;
      logic [12:0] rl;
      fc = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(2, 64));
      rl = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191)) : 13'($urandom_range(1, 512));
      set_config(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255) % (32'(fc) + 1)),
                 9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255) % (32'(fc) + 1)), fc, rl);
   endtask

   task automatic test_random();
      logic [15:0] st, sp;
      int span;
      for (int ph = 0; ph < 30; ph++) begin
         random_config();
         span = (sh_fc < 2 ? 2 : sh_fc) * 256;
         for (int n = 0; n < 28; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               st = 16'($urandom);
               sp = 16'($urandom);
            end else begin
               st = 16'({sh_cur, 8'h0} + $urandom_range(0, 1023) - 512);
               sp = 16'($urandom_range(0, span > 65535 ? 65535 : span));
            end
            send_sample(st, sp, 12'($urandom_range(0, 4095)), 1'b1);
         end
         end_burst();
      end
   endtask

   task automatic test_backpressure();
      set_config(vsm_pkg::MODE_TORNADO, 8'd3, 9'd9, 4'd2, 8'd12, 9'd40, 13'd128);
      stall_hold = 300;
      for (int n = 0; n < 60; n++)
         send_sample(16'($urandom), 16'($urandom_range(0, 40 * 256)),
                     12'($urandom_range(0, 200)), 1'b0);
      end_burst();
      drain();
      for (int n = 0; n < 20; n++)
         send_sample(16'($urandom), 16'($urandom_range(0, 40 * 256)),
                     12'($urandom_range(0, 200)), 1'b0);
      end_burst();
   endtask

   initial begin
      sh_mode = vsm_pkg::MODE_NONE; sh_wc = 8'd1; sh_we = 9'd4; sh_pw = 4'd3;
      sh_cur = 8'd0; sh_fc = 9'd32; sh_rl = 13'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (GEO_WAIT + 2) @(posedge clock);
      test_defaults();
      test_modes_directed();
      test_backpressure();
      test_random();
      drain();
      if (failed) $display("== FAIL ==");
      else $display("== PASS ==");
      $finish;
   end

endmodule
